// ===== rtl/euler_to_quaternion_macros.svh =====
// Assertion macros shared by the euler_to_quaternion RTL.
// Depends on nothing; the user module must have ports named clock and reset.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define EQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`define EQ_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) (cond)) \
      else $error("invariant check failed");
`else
`define EQ_ASSERT_NOW(lbl, ante, cons)
`define EQ_ASSERT_NEXT(lbl, ante, cons)
`define EQ_ASSERT_ALWAYS(lbl, cond)
`endif
`endif

// ===== rtl/eq_pkg.sv =====
// Shared constants and types for the Euler angle to quaternion pipeline.
// Depends on nothing.
package eq_pkg;
   localparam int ANGLE_FRAC_BITS_DEF = 6;
   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int ANG_SCALE_BITS      = 22;
   localparam int TRIG_W              = 32;
   localparam int Q15_W               = 16;
   localparam int ANGLE_W             = 16;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032875;
   localparam logic signed [Q15_W-1:0]  Q15_MAX         = 16'sd32767;

   typedef logic signed [TRIG_W-1:0] trig_type;

   // Arctangent of 2^-i in degrees scaled by 2^22, rounded to nearest.
   function automatic logic signed [31:0] atan_q22(input int idx);
      logic signed [31:0] v;
      case (idx)
         0:  v = 32'sd188743680;
         1:  v = 32'sd111421900;
         2:  v = 32'sd58872272;
         3:  v = 32'sd29884485;
         4:  v = 32'sd15000234;
         5:  v = 32'sd7507429;
         6:  v = 32'sd3754631;
         7:  v = 32'sd1877430;
         8:  v = 32'sd938729;
         9:  v = 32'sd469366;
         10: v = 32'sd234683;
         11: v = 32'sd117342;
         12: v = 32'sd58671;
         13: v = 32'sd29335;
         14: v = 32'sd14668;
         15: v = 32'sd7334;
         16: v = 32'sd3667;
         17: v = 32'sd1833;
         18: v = 32'sd917;
         19: v = 32'sd458;
         20: v = 32'sd229;
         21: v = 32'sd115;
         22: v = 32'sd57;
         23: v = 32'sd29;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction
endpackage

// ===== rtl/eq_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine of half an angle.
// Depends on eq_pkg; one CORDIC iteration per register stage, between an input stage and a sign-restore stage.
module eq_cordic
   import eq_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic signed [ANGLE_W-1:0] angle,
   output trig_type                  cos_half,
   output trig_type                  sin_half
);
   localparam int ZW = 45 - ANGLE_FRAC_BITS;
   localparam int SH = ANG_SCALE_BITS - 1 - ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] QUARTER   = ZW'(64'sd90 <<< ANG_SCALE_BITS);
   localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd180 <<< ANG_SCALE_BITS);

   logic signed [ZW-1:0] z_ff [0:CORDIC_STAGES];
   logic signed [ZW-1:0] z_in [0:CORDIC_STAGES];
   trig_type             x_ff [0:CORDIC_STAGES];
   trig_type             x_in [0:CORDIC_STAGES];
   trig_type             y_ff [0:CORDIC_STAGES];
   trig_type             y_in [0:CORDIC_STAGES];
   logic                 flip_ff [0:CORDIC_STAGES];
   trig_type             cos_ff, sin_ff, cos_in, sin_in;
   logic signed [ZW-1:0] z_raw;

   // Input stage: scale to half-angle units and fold into -90..+90 degrees.
   always_comb begin
      z_raw = {{(ZW-ANGLE_W){angle[ANGLE_W-1]}}, angle} <<< SH;
      x_in[0] = CORDIC_GAIN_Q30;
      y_in[0] = '0;
      if (z_raw > QUARTER) begin
         z_in[0] = z_raw - HALF_TURN;
      end else if (z_raw < -QUARTER) begin
         z_in[0] = z_raw + HALF_TURN;
      end else begin
         z_in[0] = z_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[0]    <= z_in[0];
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         flip_ff[0] <= (z_raw > QUARTER) || (z_raw < -QUARTER);
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q22(i));
      always_comb begin
         if (!z_ff[i][ZW-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ATAN;
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ATAN;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            z_ff[i+1]    <= z_in[i+1];
            x_ff[i+1]    <= x_in[i+1];
            y_ff[i+1]    <= y_in[i+1];
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // Undo the fold by negating both results.
   always_comb begin
      cos_in = flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
      sin_in = flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_half = cos_ff;
   assign sin_half = sin_ff;
   logic unused_reset;
   assign unused_reset = reset;
endmodule

// ===== rtl/eq_combine.sv =====
// Three-stage product network forming the quaternion from half-angle trig.
// Depends on eq_pkg; pairwise products, triple products, then sum, round and clamp.
module eq_combine
   import eq_pkg::*;
(
   input  logic                    clock,
   input  logic                    enable,
   input  trig_type                cp, sp, cy, sy, cr, sr,
   output logic signed [Q15_W-1:0] quat_w, quat_x, quat_y, quat_z
);
   localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;
   localparam logic signed [64:0] HALF_Q45 = 65'sd1 <<< 44;

   trig_type crcp_ff, srsp_ff, crsp_ff, srcp_ff;
   trig_type crcp_in, srsp_in, crsp_in, srcp_in;
   trig_type cy_d_ff, sy_d_ff;
   logic signed [63:0] p_ff [8];
   logic signed [63:0] p_in [8];
   logic signed [Q15_W-1:0] q_ff [4];
   logic signed [Q15_W-1:0] q_in [4];
   logic signed [63:0] m0, m1, m2, m3;
   logic signed [64:0] s [4];
   logic signed [64:0] rs [4];

   function automatic logic signed [Q15_W-1:0] sat(input logic signed [19:0] r);
      logic signed [Q15_W-1:0] v;
      if (r > 20'sd32767) begin
         v = Q15_MAX;
      end else if (r < -20'sd32767) begin
         v = -Q15_MAX;
      end else begin
         v = r[Q15_W-1:0];
      end
      return v;
   endfunction

   always_comb begin
      m0 = 64'(cr) * 64'(cp) + HALF_Q30;
      m1 = 64'(sr) * 64'(sp) + HALF_Q30;
      m2 = 64'(cr) * 64'(sp) + HALF_Q30;
      m3 = 64'(sr) * 64'(cp) + HALF_Q30;
      crcp_in = m0[61:30];
      srsp_in = m1[61:30];
      crsp_in = m2[61:30];
      srcp_in = m3[61:30];
   end

   always_comb begin
      p_in[0] = 64'(crcp_ff) * 64'(cy_d_ff);
      p_in[1] = 64'(srsp_ff) * 64'(sy_d_ff);
      p_in[2] = 64'(crsp_ff) * 64'(cy_d_ff);
      p_in[3] = 64'(srcp_ff) * 64'(sy_d_ff);
      p_in[4] = 64'(crcp_ff) * 64'(sy_d_ff);
      p_in[5] = 64'(srsp_ff) * 64'(cy_d_ff);
      p_in[6] = 64'(srcp_ff) * 64'(cy_d_ff);
      p_in[7] = 64'(crsp_ff) * 64'(sy_d_ff);
   end

   always_comb begin
      s[0] = 65'(p_ff[0]) + 65'(p_ff[1]);
      s[1] = 65'(p_ff[2]) + 65'(p_ff[3]);
      s[2] = 65'(p_ff[4]) - 65'(p_ff[5]);
      s[3] = 65'(p_ff[6]) - 65'(p_ff[7]);
      for (int k = 0; k < 4; k++) begin
         rs[k]   = s[k] + HALF_Q45;
         q_in[k] = sat(rs[k][64:45]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         crcp_ff <= crcp_in;
         srsp_ff <= srsp_in;
         crsp_ff <= crsp_in;
         srcp_ff <= srcp_in;
         cy_d_ff <= cy;
         sy_d_ff <= sy;
         p_ff    <= p_in;
         q_ff    <= q_in;
      end
   end

   assign quat_w = q_ff[0];
   assign quat_x = q_ff[1];
   assign quat_y = q_ff[2];
   assign quat_z = q_ff[3];
endmodule

// ===== rtl/euler_to_quaternion.sv =====
// Top level of the Euler angle to unit quaternion converter.
// Depends on eq_pkg, eq_cordic, eq_combine and euler_to_quaternion_macros.svh.

// Each input word carries pitch, yaw and roll in degrees as signed fixed point
// with ANGLE_FRAC_BITS fraction bits; each output word carries the quaternion
// (w,x,y,z) as signed Q1.15, clamped to plus or minus 32767. The block takes
// one word every cycle and returns exactly one word per input word, in order.
// The pipeline is made of the three parallel CORDIC pipelines, one iteration per
// stage, plus an input scaling stage, a sign-restore stage and three stages
// of multiplication, summing and saturation. The whole pipeline advances as
// one: when the output word is held by the consumer the pipeline freezes and
// req_tready drops, otherwise a new word is taken every cycle. There is no
// state between words and nothing to configure.
`include "euler_to_quaternion_macros.svh"
module euler_to_quaternion
   import eq_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // pitch_deg [15:0], yaw_deg [31:16], roll_deg [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
);
   localparam int LAT = CORDIC_STAGES + 5;

   logic [LAT-1:0] valid_ff, valid_in;
   logic           advance;
   logic           min_code_out;
   trig_type       cp, sp, cy, sy, cr, sr;
   logic signed [Q15_W-1:0] quat_w, quat_x, quat_y, quat_z;

   // The pipeline moves whenever the last stage is empty or being taken.
   assign advance    = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_comb begin
      valid_in = advance ? {valid_ff[LAT-2:0], req_tvalid} : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   eq_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .reset(reset), .enable(advance),
      .angle(req_tdata[15:0]), .cos_half(cp), .sin_half(sp));

   eq_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .reset(reset), .enable(advance),
      .angle(req_tdata[31:16]), .cos_half(cy), .sin_half(sy));

   eq_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .reset(reset), .enable(advance),
      .angle(req_tdata[47:32]), .cos_half(cr), .sin_half(sr));

   eq_combine u_combine (
      .clock(clock), .enable(advance),
      .cp(cp), .sp(sp), .cy(cy), .sy(sy), .cr(cr), .sr(sr),
      .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z));

   assign rsp_tdata = {quat_z, quat_y, quat_x, quat_w};

   // High when any component holds the most negative code.
   assign min_code_out = (quat_w == -16'sd32768) || (quat_x == -16'sd32768) ||
                         (quat_y == -16'sd32768) || (quat_z == -16'sd32768);

   // Saturation never produces the most negative code.
   `EQ_ASSERT_NOW(a_no_min_code, rsp_tvalid, !min_code_out)
   // A held output freezes every valid bit in the pipeline.
   `EQ_ASSERT_NEXT(a_freeze, rsp_tvalid && !rsp_tready, $stable(valid_ff))
   // An accepted word enters the first stage.
   `EQ_ASSERT_NEXT(a_enter, req_tvalid && req_tready, valid_ff[0])
   // Reset empties the pipeline.
   `EQ_ASSERT_ALWAYS(a_reset_clear, !$past(reset) || reset || (valid_ff == '0))
endmodule
